/* hw/rtl/ber_tag_length_header_parser_top_defines.svh */
// Assertion macros for the BER tag and length header parser.
`ifndef BER_TAG_LENGTH_HEADER_PARSER_TOP_DEFINES_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BERTLH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BERTLH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bertlh_pkg.sv */
// Package with item types, codes and defaults of the BER header parser.
package bertlh_pkg;

    localparam int DEF_MAX_LENGTH_BYTES = 8;
    localparam int DEF_TAG_WIDTH        = 64;

    localparam logic [1:0] PH_IDENT    = 2'd0;
    localparam logic [1:0] PH_TAG      = 2'd1;
    localparam logic [1:0] PH_LEN      = 2'd2;
    localparam logic [1:0] PH_LENBYTES = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_MALFORMED    = 3'd1;
    localparam logic [2:0] ST_TOO_WIDE     = 3'd2;
    localparam logic [2:0] ST_TRUNCATED    = 3'd3;
    localparam logic [2:0] ST_TAG_OVERFLOW = 3'd4;

    localparam logic [7:0] CONT_BIT   = 8'h80;
    localparam logic [6:0] LOW7_MASK  = 7'h7f;
    localparam logic [4:0] HIGH_TAG   = 5'h1f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  class_bits;
        logic        constructed;
        logic [63:0] tag_number;
        logic [63:0] length_value;
        logic [2:0]  status;
    } t_out_item;

endpackage

/* hw/rtl/bertlh_stream_if.sv */
// Valid/ready stream interface that carries one item per handshake.
interface bertlh_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/ber_tag_length_header_parser_top.sv */
// Top level of the BER identifier and length header parser.
// Data path: an accepted item is registered in the input register, then decoded into
// the result register once the result register is free or its result is being taken.
// Throughput: one header byte per cycle unless the output stalls; the input register
// and the result register let a new item enter while a finished result waits to be taken.
// Reset: synchronous active-low reset empties both registers and returns the
// parser to expecting an identifier byte.
`include "ber_tag_length_header_parser_top_defines.svh"

module ber_tag_length_header_parser_top #(
    parameter int MAX_LENGTH_BYTES = bertlh_pkg::DEF_MAX_LENGTH_BYTES,
    parameter int TAG_WIDTH        = bertlh_pkg::DEF_TAG_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    bertlh_stream_if.sink           i_in,
    bertlh_stream_if.source         o_out
);

    localparam int CW = $clog2(MAX_LENGTH_BYTES + 1);

    logic                  r_in_valid;
    bertlh_pkg::t_in_item  r_in;
    logic                  r_out_valid;
    bertlh_pkg::t_out_item r_out;

    logic [1:0]            r_phase,  n_phase;
    logic [1:0]            r_class,  n_class;
    logic                  r_cons,   n_cons;
    logic [TAG_WIDTH-1:0]  r_tag,    n_tag;
    logic                  r_first,  n_first;
    logic [63:0]           r_len,    n_len;
    logic [CW-1:0]         r_left,   n_left;
    logic [CW-1:0]         r_count,  n_count;

    logic                  w_adv;
    logic                  w_emit;
    logic [2:0]            w_status;
    logic [7:0]            w_b;
    logic [6:0]            w_cnt;
    logic [CW-1:0]         w_left_dec;
    logic [5:0]            w_shamt;
    bertlh_pkg::t_out_item w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    assign w_b     = r_in.data_byte;
    assign w_cnt   = w_b[6:0] & bertlh_pkg::LOW7_MASK;
    assign w_shamt = {3'(r_count - CW'(1)), 3'b000};

    always_comb begin
        n_phase    = r_phase;
        n_class    = r_class;
        n_cons     = r_cons;
        n_tag      = r_tag;
        n_first    = r_first;
        n_len      = r_len;
        n_left     = r_left;
        n_count    = r_count;
        w_emit     = 1'b0;
        w_status   = bertlh_pkg::ST_OK;
        w_left_dec = r_left;
        case (r_phase)
            bertlh_pkg::PH_IDENT: begin
                n_class = w_b[7:6];
                n_cons  = w_b[5];
                if (w_b[4:0] != bertlh_pkg::HIGH_TAG) begin
                    n_tag   = TAG_WIDTH'(w_b[4:0]);
                    n_phase = bertlh_pkg::PH_LEN;
                end else begin
                    n_tag   = '0;
                    n_first = 1'b1;
                    n_phase = bertlh_pkg::PH_TAG;
                end
            end
            bertlh_pkg::PH_TAG: begin
                if (r_first && (w_b == bertlh_pkg::CONT_BIT)) begin
                    w_emit   = 1'b1;
                    w_status = bertlh_pkg::ST_MALFORMED;
                end else if (r_tag[TAG_WIDTH-1 -: 7] != 7'd0) begin
                    w_emit   = 1'b1;
                    w_status = bertlh_pkg::ST_TAG_OVERFLOW;
                end else begin
                    n_first = 1'b0;
                    n_tag   = {r_tag[TAG_WIDTH-8:0], w_cnt};
                    if (!w_b[7]) begin
                        n_phase = bertlh_pkg::PH_LEN;
                    end
                end
            end
            bertlh_pkg::PH_LEN: begin
                if (!w_b[7]) begin
                    n_len  = 64'(w_b);
                    w_emit = 1'b1;
                end else if (w_cnt == 7'd0) begin
                    w_emit   = 1'b1;
                    w_status = bertlh_pkg::ST_MALFORMED;
                end else if (w_cnt > 7'(MAX_LENGTH_BYTES)) begin
                    w_emit   = 1'b1;
                    w_status = bertlh_pkg::ST_TOO_WIDE;
                end else begin
                    n_len   = '0;
                    n_left  = CW'(w_cnt);
                    n_count = CW'(w_cnt);
                    n_phase = bertlh_pkg::PH_LENBYTES;
                end
            end
            default: begin
                n_len = {r_len[55:0], w_b};
                if (r_left != '0) begin
                    w_left_dec = r_left - CW'(1);
                end
                n_left = w_left_dec;
                if (w_left_dec == '0) begin
                    w_emit = 1'b1;
                    if ((r_count == '0) || (r_count > CW'(MAX_LENGTH_BYTES))) begin
                        w_status = bertlh_pkg::ST_MALFORMED;
                    end else if (n_len[63:7] == 57'd0) begin
                        w_status = bertlh_pkg::ST_MALFORMED;
                    end else if ((n_len >> w_shamt) == 64'd0) begin
                        w_status = bertlh_pkg::ST_MALFORMED;
                    end
                end
            end
        endcase
        if (!w_emit && r_in.last_byte) begin
            w_emit   = 1'b1;
            w_status = bertlh_pkg::ST_TRUNCATED;
        end

        w_res.class_bits   = n_class;
        w_res.constructed  = n_cons;
        w_res.tag_number   = (w_status == bertlh_pkg::ST_OK) ? 64'(n_tag) : 64'd0;
        w_res.length_value = (w_status == bertlh_pkg::ST_OK) ? n_len : 64'd0;
        w_res.status       = w_status;

        if (w_emit) begin
            n_phase = bertlh_pkg::PH_IDENT;
            n_class = 2'd0;
            n_cons  = 1'b0;
            n_tag   = '0;
            n_first = 1'b1;
            n_len   = '0;
            n_left  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= bertlh_pkg::PH_IDENT;
            r_first     <= 1'b1;
            r_left      <= '0;
            r_count     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_first <= n_first;
                r_left  <= n_left;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (w_adv) begin
            r_class <= n_class;
            r_cons  <= n_cons;
            r_tag   <= n_tag;
            r_len   <= n_len;
        end
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    `BERTLH_ASSERT_IMP(a_err_fields_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.status != bertlh_pkg::ST_OK),
        (r_out.tag_number == 64'd0) && (r_out.length_value == 64'd0),
        "Error result carries a nonzero tag or length.")
    `BERTLH_ASSERT_NXT(a_restart_after_result, i_clk, i_rst_n,
        w_adv && w_emit,
        (r_phase == bertlh_pkg::PH_IDENT) && r_first,
        "Parser did not restart after a result.")
    `BERTLH_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n,
        !r_in_valid,
        i_in.ready,
        "Input not ready although the input register is empty.")
    `BERTLH_ASSERT_NXT(a_result_held, i_clk, i_rst_n,
        r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_out),
        "Stalled result was lost or changed.")

endmodule
